// ----- design/ffd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the fixed-length frame deframer.
// No dependencies.
package ffd_pkg;

    localparam int FRAME_LEN = 12;
    localparam int WIN_LEN   = FRAME_LEN - 1;
    localparam int FILL_W    = 4;

    typedef logic [7:0]        t_byte;
    typedef logic [15:0]       t_word;
    typedef logic [FILL_W-1:0] t_fill;

    localparam t_fill FILL_FULL = t_fill'(WIN_LEN);

    typedef enum logic [1:0] {
        CFG_HEADER_FIRST  = 2'd0,
        CFG_HEADER_SECOND = 2'd1,
        CFG_TAIL_FIRST    = 2'd2,
        CFG_TAIL_SECOND   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_byte header_first;
        t_byte header_second;
        t_byte tail_first;
        t_byte tail_second;
    } t_cfg;

    typedef struct packed {
        logic  hit;
        t_word dev_class;
        t_word command;
        t_word payload;
        logic  checksum_ok;
    } t_frame;

endpackage

// ----- design/ffd_cfg.sv -----
`timescale 1ns / 1ps
// Configuration registers: expected header and tail bytes.
// Depends on ffd_pkg.
module ffd_cfg
    import ffd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_idx,
    input  t_byte    i_cfg_data,
    output t_cfg     o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HEADER_FIRST:  n_cfg.header_first  = i_cfg_data;
                CFG_HEADER_SECOND: n_cfg.header_second = i_cfg_data;
                CFG_TAIL_FIRST:    n_cfg.tail_first    = i_cfg_data;
                CFG_TAIL_SECOND:   n_cfg.tail_second   = i_cfg_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/ffd_window.sv -----
`timescale 1ns / 1ps
// Byte window with fill count, frame match and checksum test.
// Depends on ffd_pkg.
module ffd_window
    import ffd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  t_byte  i_byte,
    input  t_cfg   i_cfg,
    output t_frame o_frame
);

    t_byte r_win [WIN_LEN];
    t_byte n_win [WIN_LEN];
    t_fill r_fill;
    t_fill n_fill;
    t_frame frame;
    logic   full;
    t_word  sum;

    assign full = (r_fill == FILL_FULL);

    always_comb begin
        frame             = '0;
        frame.dev_class   = {r_win[3], r_win[2]};
        frame.command     = {r_win[5], r_win[4]};
        frame.payload     = {r_win[7], r_win[6]};
        sum               = {r_win[9], r_win[8]};
        frame.checksum_ok = (sum == t_word'(frame.command + frame.payload));
        frame.hit = full
                 && (r_win[0] == i_cfg.header_first)
                 && (r_win[1] == i_cfg.header_second)
                 && (r_win[WIN_LEN-1] == i_cfg.tail_first)
                 && (i_byte == i_cfg.tail_second);
    end

    always_comb begin
        n_win  = r_win;
        n_fill = r_fill;
        if (i_adv) begin
            if (full) begin
                if (frame.hit) begin
                    n_fill = '0;
                end else begin
                    for (int i = 0; i < WIN_LEN - 1; i++) begin
                        n_win[i] = r_win[i+1];
                    end
                    n_win[WIN_LEN-1] = i_byte;
                end
            end else begin
                for (int i = 0; i < WIN_LEN; i++) begin
                    if (r_fill == t_fill'(i)) begin
                        n_win[i] = i_byte;
                    end
                end
                n_fill = r_fill + t_fill'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    assign o_frame = frame;

endmodule

// ----- design/fixed_frame_deframer_sum16.sv -----
`timescale 1ns / 1ps
// Fixed-length frame deframer with 16-bit additive checksum, top level.
// A result is captured in the output register once the last byte of its frame, held in the input register, proceeds.
// Throughput: one byte beat per cycle when not stalled, set by the window update.
// A byte that ends a frame waits only while a previous result is stalled.
// Reset (synchronous, active low) clears the config registers, fill count and valids.
module fixed_frame_deframer_sum16
    import ffd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_idx,
    input  t_byte    i_cfg_data,
    input  logic     i_rx_valid,
    output logic     o_rx_stall,
    input  t_byte    i_rx_byte,
    output logic     o_res_valid,
    input  logic     i_res_stall,
    output t_word    o_dev_class,
    output t_word    o_command,
    output t_word    o_payload,
    output logic     o_checksum_ok
);

    t_cfg   cfg;
    t_frame frame;
    logic   r_in_valid;
    t_byte  r_in_byte;
    logic   r_out_valid;
    t_frame r_out;
    logic   proceed;

    ffd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ffd_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (proceed),
        .i_byte  (r_in_byte),
        .i_cfg   (cfg),
        .o_frame (frame)
    );

    assign proceed    = r_in_valid && (!frame.hit || !r_out_valid || !i_res_stall);
    assign o_rx_stall = r_in_valid && !proceed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_rx_stall) begin
                r_in_valid <= i_rx_valid;
            end
            if (proceed && frame.hit) begin
                r_out_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && !o_rx_stall) begin
            r_in_byte <= i_rx_byte;
        end
        if (proceed && frame.hit) begin
            r_out <= frame;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_dev_class   = r_out.dev_class;
    assign o_command     = r_out.command;
    assign o_payload     = r_out.payload;
    assign o_checksum_ok = r_out.checksum_ok;

endmodule
